// ----- sv/mfd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the multitap feedback delay.
package mfd_pkg;

    // Word field widths.
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int OUT_W       = 24;
    localparam int DELAY_W     = 18;
    localparam int COUNT_W     = 4;
    localparam int SELECT_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    // Datapath widths: a 24 x 16 product, and a sum of up to sixteen of them.
    localparam int PROD_W  = OUT_W + GAIN_W;
    localparam int ACC_W   = 46;
    localparam int Q_SHIFT = 14;

    // Delay limits.
    localparam int MIN_TAP_DELAY = 256;
    localparam int DELAY_GUARD   = 1024;

    // Parameter defaults.
    localparam int DEF_DELAY_DEPTH = 262144;
    localparam int DEF_TAP_SLOTS   = 8;

    // Register reset values.
    localparam logic signed [GAIN_W-1:0]  RST_DRY_GAIN  = 16'sd11585;
    localparam logic signed [GAIN_W-1:0]  RST_TAP_GAIN  = 16'sd5793;
    localparam logic signed [GAIN_W-1:0]  RST_FB_GAIN   = 16'sd4096;
    localparam logic [DELAY_W-1:0]        RST_TAP_DELAY = 18'd256;
    localparam logic [COUNT_W-1:0]        RST_TAP_COUNT = 4'd1;
    localparam logic [SELECT_W-1:0]       RST_TAP_SEL   = 3'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRY_LEFT_GAIN  = 3'd0,
        REG_DRY_RIGHT_GAIN = 3'd1,
        REG_TAP_COUNT      = 3'd2,
        REG_TAP_SELECT     = 3'd3,
        REG_TAP_DELAY      = 3'd4,
        REG_TAP_LEFT_GAIN  = 3'd5,
        REG_TAP_RIGHT_GAIN = 3'd6,
        REG_TAP_FB_GAIN    = 3'd7
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DRY_L,
        S_DRY_R,
        S_TAP_RD,
        S_TAP_L,
        S_TAP_R,
        S_TAP_FB,
        S_FLUSH,
        S_WRITE
    } state_t;

    // Operation issued to the shared multiplier.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DRY_L,
        OP_DRY_R,
        OP_TAP_L,
        OP_TAP_R,
        OP_TAP_FB
    } mac_op_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic    load;       // start of a word: clear sums, latch sample
        mac_op_t op;         // product to form this cycle
        logic    sig_valid;  // tap read hit a written entry
        logic    out_load;   // capture the rounded sums into the output
    } mac_ctrl_t;

    // Round a Q.14 value to nearest, ties toward plus infinity.
    function automatic logic signed [ACC_W-1:0] round_q14(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] biased;
        biased = v + ACC_W'(1 << (Q_SHIFT - 1));
        return biased >>> Q_SHIFT;
    endfunction

    // Saturate to the 24-bit output range.
    function automatic logic signed [OUT_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((1 << (OUT_W - 1)) - 1);
        lo = -ACC_W'(1 << (OUT_W - 1));
        if (v > hi) begin
            return OUT_W'(hi);
        end
        if (v < lo) begin
            return OUT_W'(lo);
        end
        return OUT_W'(v);
    endfunction

endpackage

// ----- sv/mfd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/mfd_mac.sv -----
// Shared multiplier with left, right and feedback accumulators and output register.
module mfd_mac
    import mfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic signed [OUT_W-1:0]    tap_data,
    input  logic signed [GAIN_W-1:0]   dry_left_gain,
    input  logic signed [GAIN_W-1:0]   dry_right_gain,
    input  logic signed [GAIN_W-1:0]   tap_left_gain,
    input  logic signed [GAIN_W-1:0]   tap_right_gain,
    input  logic signed [GAIN_W-1:0]   tap_feedback_gain,
    output logic signed [OUT_W-1:0]    entry,
    output logic signed [OUT_W-1:0]    left_out,
    output logic signed [OUT_W-1:0]    right_out
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    mac_op_t                    op_reg;
    logic signed [ACC_W-1:0]    acc_l_reg;
    logic signed [ACC_W-1:0]    acc_l_next;
    logic signed [ACC_W-1:0]    acc_r_reg;
    logic signed [ACC_W-1:0]    acc_r_next;
    logic signed [OUT_W-1:0]    entry_reg;
    logic signed [OUT_W-1:0]    entry_next;
    logic signed [OUT_W-1:0]    left_reg;
    logic signed [OUT_W-1:0]    right_reg;
    logic signed [OUT_W-1:0]    mul_a;
    logic signed [GAIN_W-1:0]   mul_b;
    logic signed [OUT_W-1:0]    tap_sig;

    // A tap that reaches an entry never written reads as silence.
    assign tap_sig = ctrl.sig_valid ? tap_data : '0;

    // Operand selection for the single multiplier.
    always_comb
    begin
        mul_a = tap_sig;
        mul_b = '0;
        unique case (ctrl.op)
            OP_DRY_L:
            begin
                mul_a = OUT_W'(sample_reg);
                mul_b = dry_left_gain;
            end
            OP_DRY_R:
            begin
                mul_a = OUT_W'(sample_reg);
                mul_b = dry_right_gain;
            end
            OP_TAP_L:  mul_b = tap_left_gain;
            OP_TAP_R:  mul_b = tap_right_gain;
            OP_TAP_FB: mul_b = tap_feedback_gain;
            default:   mul_b = '0;
        endcase
        prod_next = mul_a * mul_b;
    end

    // Accumulate the product registered in the previous cycle.
    always_comb
    begin
        acc_l_next = acc_l_reg;
        acc_r_next = acc_r_reg;
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            acc_l_next = '0;
            acc_r_next = '0;
            entry_next = OUT_W'(sample_in);
        end
        else
        begin
            unique case (op_reg)
                OP_DRY_L, OP_TAP_L: acc_l_next = acc_l_reg + ACC_W'(prod_reg);
                OP_DRY_R, OP_TAP_R: acc_r_next = acc_r_reg + ACC_W'(prod_reg);
                OP_TAP_FB:
                begin
                    entry_next = sat24(ACC_W'(entry_reg) + round_q14(ACC_W'(prod_reg)));
                end
                default:
                begin
                    acc_l_next = acc_l_reg;
                end
            endcase
        end
    end

    // Operation tag, registered alongside its product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_NONE;
        end
        else
        begin
            op_reg <= ctrl.op;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        acc_l_reg <= acc_l_next;
        acc_r_reg <= acc_r_next;
        entry_reg <= entry_next;
        if (ctrl.load)
        begin
            sample_reg <= sample_in;
        end
        if (ctrl.out_load)
        begin
            left_reg  <= sat24(round_q14(acc_l_reg));
            right_reg <= sat24(round_q14(acc_r_reg));
        end
    end

    assign entry     = entry_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule

// ----- sv/mfd_ctrl.sv -----
// Sequencer: word handshakes, tap loop, delay store addressing and write position.
module mfd_ctrl
    import mfd_pkg::*;
#(
    parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
    parameter int TAP_SLOTS   = DEF_TAP_SLOTS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    input  logic [COUNT_W-1:0]                            tap_count,
    input  logic [DELAY_W-1:0]                            tap_delay,
    output logic [((TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1)-1:0] tap_idx,
    output mac_ctrl_t                                     mac_ctrl,
    output logic                                          ram_rd_en,
    output logic [$clog2(DELAY_DEPTH)-1:0]                ram_rd_addr,
    output logic                                          ram_wr_en,
    output logic [$clog2(DELAY_DEPTH)-1:0]                ram_wr_addr
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int TIW   = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
    localparam int CNT_W = $clog2(TAP_SLOTS + 1);
    localparam int CW    = (AW > DELAY_W) ? AW : DELAY_W;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic             wrapped_reg;
    logic             wrapped_next;
    logic             sig_valid_reg;
    logic             sig_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] active_taps;
    logic             last_tap;
    logic             out_free;
    logic [CW-1:0]    d_ext;
    logic [CW-1:0]    d_clamped;
    logic [AW:0]      diff;
    logic [AW:0]      rp_full;
    logic             rp_written;

    // Number of active taps, limited to the slots that exist.
    assign active_taps = (32'(tap_count) > TAP_SLOTS) ? CNT_W'(TAP_SLOTS) : CNT_W'(tap_count);
    assign last_tap    = ((idx_reg + CNT_W'(1)) == active_taps);
    assign out_free    = !out_valid_reg || out_ready;
    assign tap_idx     = idx_reg[TIW-1:0];

    // Clamp the tap delay and form the read position behind the write position.
    always_comb
    begin
        d_ext = CW'(tap_delay);
        priority if (d_ext < CW'(MIN_TAP_DELAY))
        begin
            d_clamped = CW'(MIN_TAP_DELAY);
        end
        else if (d_ext > CW'(DELAY_DEPTH - DELAY_GUARD))
        begin
            d_clamped = CW'(DELAY_DEPTH - DELAY_GUARD);
        end
        else
        begin
            d_clamped = d_ext;
        end
        diff    = {1'b0, wp_reg} - {1'b0, d_clamped[AW-1:0]};
        rp_full = diff[AW] ? diff + (AW+1)'(DELAY_DEPTH) : diff;
        // Before the first wrap, only positions below the write position hold data.
        rp_written = wrapped_reg || !diff[AW];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DRY_L;
                end
            end
            S_DRY_L:  state_next = S_DRY_R;
            S_DRY_R:  state_next = (active_taps == '0) ? S_FLUSH : S_TAP_RD;
            S_TAP_RD: state_next = S_TAP_L;
            S_TAP_L:  state_next = S_TAP_R;
            S_TAP_R:  state_next = S_TAP_FB;
            S_TAP_FB: state_next = last_tap ? S_FLUSH : S_TAP_RD;
            S_FLUSH:  state_next = S_WRITE;
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready           = 1'b0;
        ram_rd_en          = 1'b0;
        ram_wr_en          = 1'b0;
        mac_ctrl.load      = 1'b0;
        mac_ctrl.op        = OP_NONE;
        mac_ctrl.sig_valid = sig_valid_reg;
        mac_ctrl.out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                mac_ctrl.load = in_valid;
            end
            S_DRY_L:  mac_ctrl.op = OP_DRY_L;
            S_DRY_R:  mac_ctrl.op = OP_DRY_R;
            S_TAP_RD: ram_rd_en   = 1'b1;
            S_TAP_L:  mac_ctrl.op = OP_TAP_L;
            S_TAP_R:  mac_ctrl.op = OP_TAP_R;
            S_TAP_FB: mac_ctrl.op = OP_TAP_FB;
            S_FLUSH:  mac_ctrl.op = OP_NONE;
            S_WRITE:
            begin
                ram_wr_en         = out_free;
                mac_ctrl.out_load = out_free;
            end
            default:  mac_ctrl.op = OP_NONE;
        endcase
    end

    assign ram_rd_addr = rp_full[AW-1:0];
    assign ram_wr_addr = wp_reg;
    assign out_valid   = out_valid_reg;

    // Next values of the loop counter, write position and output flag.
    always_comb
    begin
        idx_next       = idx_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        sig_valid_next = sig_valid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == S_IDLE)
        begin
            idx_next = '0;
        end
        if (state_reg == S_TAP_RD)
        begin
            sig_valid_next = rp_written;
        end
        if (state_reg == S_TAP_FB)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (state_reg == S_WRITE && out_free)
        begin
            out_valid_next = 1'b1;
            if (wp_reg == AW'(DELAY_DEPTH - 1))
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            sig_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            sig_valid_reg <= sig_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/multitap_feedback_delay.sv -----
// Top level of the multitap stereo delay with feedback.
//
// Usage: each input word on in_valid/in_ready carries one signed mono sample;
// each output word on out_valid/out_ready carries the saturated left and right
// samples it produces. The user must write registers through cfg_we/cfg_index/
// cfg_data only while the block is idle; the block does not enforce this.
// Tap delay and gain writes go to the tap chosen by the tap select register.
// Timing: one word at a time: S_DRY_L and S_DRY_R, then S_TAP_RD, S_TAP_L,
// S_TAP_R and S_TAP_FB per active tap, then S_FLUSH and S_WRITE. out_valid
// rises as S_WRITE returns to S_IDLE, and in_ready returns in that same
// cycle. Throughput is set by the single shared multiplier, three products
// per tap, and by the one read port of the delay store, one read per tap.
// Reset: the write position returns to zero and all registers to their
// defaults. The store is not cleared; a wrap flag marks which entries have
// been written, and reads of the rest return zero, so words are accepted
// right after reset.
// Stall: a finished word waits in the output register. The next input word is
// accepted and processed meanwhile; it waits to finish until the output
// register is free.
module multitap_feedback_delay
    import mfd_pkg::*;
#(
    parameter int DELAY_DEPTH = DEF_DELAY_DEPTH,
    parameter int TAP_SLOTS   = DEF_TAP_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_W-1:0]    sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_W-1:0]       left_out,
    output logic signed [OUT_W-1:0]       right_out,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int AW  = $clog2(DELAY_DEPTH);
    localparam int TIW = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;

    logic signed [GAIN_W-1:0] dry_left_reg;
    logic signed [GAIN_W-1:0] dry_right_reg;
    logic [COUNT_W-1:0]       tap_count_reg;
    logic [SELECT_W-1:0]      tap_select_reg;
    logic [DELAY_W-1:0]       tap_delay_reg [TAP_SLOTS];
    logic signed [GAIN_W-1:0] tap_left_reg  [TAP_SLOTS];
    logic signed [GAIN_W-1:0] tap_right_reg [TAP_SLOTS];
    logic signed [GAIN_W-1:0] tap_fb_reg    [TAP_SLOTS];

    logic                     sel_ok;
    logic [TIW-1:0]           sel_idx;
    logic [TIW-1:0]           tap_idx;
    mac_ctrl_t                mac_ctrl;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic [OUT_W-1:0]         ram_rd_data;
    logic signed [OUT_W-1:0]  entry;

    assign sel_ok  = (32'(tap_select_reg) < TAP_SLOTS);
    assign sel_idx = TIW'(tap_select_reg);

    // Configuration registers and tap table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_left_reg   <= RST_DRY_GAIN;
            dry_right_reg  <= RST_DRY_GAIN;
            tap_count_reg  <= RST_TAP_COUNT;
            tap_select_reg <= RST_TAP_SEL;
            for (int i = 0; i < TAP_SLOTS; i++)
            begin
                tap_delay_reg[i] <= RST_TAP_DELAY;
                tap_left_reg[i]  <= RST_TAP_GAIN;
                tap_right_reg[i] <= RST_TAP_GAIN;
                tap_fb_reg[i]    <= RST_FB_GAIN;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DRY_LEFT_GAIN:  dry_left_reg   <= cfg_data[GAIN_W-1:0];
                REG_DRY_RIGHT_GAIN: dry_right_reg  <= cfg_data[GAIN_W-1:0];
                REG_TAP_COUNT:      tap_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_TAP_SELECT:     tap_select_reg <= cfg_data[SELECT_W-1:0];
                REG_TAP_DELAY:
                begin
                    if (sel_ok)
                    begin
                        tap_delay_reg[sel_idx] <= cfg_data[DELAY_W-1:0];
                    end
                end
                REG_TAP_LEFT_GAIN:
                begin
                    if (sel_ok)
                    begin
                        tap_left_reg[sel_idx] <= cfg_data[GAIN_W-1:0];
                    end
                end
                REG_TAP_RIGHT_GAIN:
                begin
                    if (sel_ok)
                    begin
                        tap_right_reg[sel_idx] <= cfg_data[GAIN_W-1:0];
                    end
                end
                REG_TAP_FB_GAIN:
                begin
                    if (sel_ok)
                    begin
                        tap_fb_reg[sel_idx] <= cfg_data[GAIN_W-1:0];
                    end
                end
                default:
                begin
                    tap_select_reg <= tap_select_reg;
                end
            endcase
        end
    end

    // Sequencer.
    mfd_ctrl #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .TAP_SLOTS   (TAP_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tap_count   (tap_count_reg),
        .tap_delay   (tap_delay_reg[tap_idx]),
        .tap_idx     (tap_idx),
        .mac_ctrl    (mac_ctrl),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr)
    );

    // Shared multiply-accumulate unit.
    mfd_mac u_mac (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (mac_ctrl),
        .sample_in         (sample_in),
        .tap_data          (ram_rd_data),
        .dry_left_gain     (dry_left_reg),
        .dry_right_gain    (dry_right_reg),
        .tap_left_gain     (tap_left_reg[tap_idx]),
        .tap_right_gain    (tap_right_reg[tap_idx]),
        .tap_feedback_gain (tap_fb_reg[tap_idx]),
        .entry             (entry),
        .left_out          (left_out),
        .right_out         (right_out)
    );

    // Circular delay store.
    mfd_ram #(
        .WIDTH (OUT_W),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (entry),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ----- dv/tb.sv -----
// Testbench for the multitap feedback delay, checked against a local echo model.
module tb
    import mfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = DEF_DELAY_DEPTH;
    localparam int TAPS        = DEF_TAP_SLOTS;
    localparam int SETTLE      = 50;
    localparam int LONG_HOLD   = 400;
    localparam int PRINT_CAP   = 100;

    typedef struct {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } stereo_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Samples waiting to be sent and stereo pairs waiting to come back.
    logic signed [SAMPLE_W-1:0] pending_samples[$];
    stereo_t stereo_due[$];

    // Shadow copy of the register file.
    logic signed [GAIN_W-1:0] dry_left_sh;
    logic signed [GAIN_W-1:0] dry_right_sh;
    logic [COUNT_W-1:0]       tap_count_sh;
    logic [SELECT_W-1:0]      tap_sel_sh;
    logic [DELAY_W-1:0]       tap_delay_sh [TAPS];
    logic signed [GAIN_W-1:0] tap_left_sh  [TAPS];
    logic signed [GAIN_W-1:0] tap_right_sh [TAPS];
    logic signed [GAIN_W-1:0] tap_fb_sh    [TAPS];

    // Local echo memory and its write pointer.
    bit signed [OUT_W-1:0] echo_store [STORE_DEPTH];
    int unsigned echo_pos = 0;

    // Traffic shaping controls set by the sequence.
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    int long_hold_asked = 0;
    int long_hold_seen;
    int send_gap;
    int hold_left;

    int error_count = 0;
    int words_out = 0;

    multitap_feedback_delay #(
        .DELAY_DEPTH(STORE_DEPTH),
        .TAP_SLOTS  (TAPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .left_out (left_out),
        .right_out(right_out),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Round a Q.14 sum to nearest with ties toward plus infinity.
    function automatic longint round_half_up(input longint v);
        return (v + (longint'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
    endfunction

    function automatic logic signed [OUT_W-1:0] clip24(input longint v);
        if (v > 64'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -64'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[OUT_W-1:0];
    endfunction

    // Mix one sample through the dry path and every active tap, updating the echo memory.
    function automatic stereo_t mix_sample(input logic signed [SAMPLE_W-1:0] s);
        stereo_t mixed;
        longint sum_l;
        longint sum_r;
        longint sig;
        int unsigned active;
        int unsigned d;
        int unsigned rd;
        sum_l = longint'(s) * longint'(dry_left_sh);
        sum_r = longint'(s) * longint'(dry_right_sh);
        echo_store[echo_pos] = s;
        active = (tap_count_sh > TAPS) ? TAPS : tap_count_sh;
        for (int unsigned t = 0; t < active; t++)
        begin
            d = tap_delay_sh[t];
            if (d < MIN_TAP_DELAY)
            begin
                d = MIN_TAP_DELAY;
            end
            if (d > STORE_DEPTH - DELAY_GUARD)
            begin
                d = STORE_DEPTH - DELAY_GUARD;
            end
            rd = (echo_pos + STORE_DEPTH - d) % STORE_DEPTH;
            sig = echo_store[rd];
            sum_l += sig * longint'(tap_left_sh[t]);
            sum_r += sig * longint'(tap_right_sh[t]);
            echo_store[echo_pos] = clip24(longint'(echo_store[echo_pos]) +
                                          round_half_up(sig * longint'(tap_fb_sh[t])));
        end
        mixed.left  = clip24(round_half_up(sum_l));
        mixed.right = clip24(round_half_up(sum_r));
        echo_pos = (echo_pos + 1) % STORE_DEPTH;
        return mixed;
    endfunction

    // Apply a register write to the shadow copy.
    function automatic void shadow_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_DRY_LEFT_GAIN:  dry_left_sh = val[GAIN_W-1:0];
            REG_DRY_RIGHT_GAIN: dry_right_sh = val[GAIN_W-1:0];
            REG_TAP_COUNT:      tap_count_sh = val[COUNT_W-1:0];
            REG_TAP_SELECT:     tap_sel_sh = val[SELECT_W-1:0];
            REG_TAP_DELAY:      tap_delay_sh[tap_sel_sh] = val[DELAY_W-1:0];
            REG_TAP_LEFT_GAIN:  tap_left_sh[tap_sel_sh] = val[GAIN_W-1:0];
            REG_TAP_RIGHT_GAIN: tap_right_sh[tap_sel_sh] = val[GAIN_W-1:0];
            REG_TAP_FB_GAIN:    tap_fb_sh[tap_sel_sh] = val[GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 80);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 16'h7FFF;
        end
        if (r < 16)
        begin
            return 16'h8000;
        end
        return 16'($urandom);
    endfunction

    // Mostly delays that reach recent history, some below the clamp range, some anywhere in the field.
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return DELAY_W'($urandom_range(0, MIN_TAP_DELAY - 1));
        end
        if (r < 30)
        begin
            return DELAY_W'($urandom);
        end
        return DELAY_W'($urandom_range(MIN_TAP_DELAY, 900));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return 16'sh7FFF;
        end
        if (r < 10)
        begin
            return 16'sh8000;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pad_gain(input logic [GAIN_W-1:0] g);
        return {2'($urandom), g};
    endfunction

    // One register write per cycle; cfg_we stays high across a burst.
    task automatic reg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        shadow_write(idx, val);
    endtask

    task automatic reg_write_end();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_tap(input int t, input logic [DELAY_W-1:0] d,
                               input logic [GAIN_W-1:0] gl, input logic [GAIN_W-1:0] gr,
                               input logic [GAIN_W-1:0] gf);
        reg_write(REG_TAP_SELECT, {15'($urandom), 3'(t)});
        reg_write(REG_TAP_DELAY, d);
        reg_write(REG_TAP_LEFT_GAIN, pad_gain(gl));
        reg_write(REG_TAP_RIGHT_GAIN, pad_gain(gr));
        reg_write(REG_TAP_FB_GAIN, pad_gain(gf));
    endtask

    // Wait until every queued word was sent and every expected pair came back.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || in_valid || stereo_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= PRINT_CAP)
        begin
            $display("ERROR word %0d: %s got %0d expected %0d", words_out, what, got, want);
        end
    endtask

    // Sender: offers queued samples, holding each word until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_in <= '0;
            send_gap <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_samples.size() != 0)
            begin
                in_valid <= 1'b1;
                sample_in <= pending_samples.pop_front();
                send_gap <= pick_gap(sender_idles);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus an occasional long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            long_hold_seen <= 0;
        end
        else if (long_hold_seen != long_hold_asked)
        begin
            long_hold_seen <= long_hold_asked;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            hold_left <= pick_gap(receiver_idles);
        end
    end

    // Monitor: check returned pairs, then predict for newly accepted samples.
    always @(posedge clk)
    begin
        stereo_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (stereo_due.size() == 0)
                begin
                    flag_mismatch("unexpected word, left", left_out, 0);
                end
                else
                begin
                    want = stereo_due.pop_front();
                    if (left_out !== want.left)
                    begin
                        flag_mismatch("left_out", left_out, want.left);
                    end
                    if (right_out !== want.right)
                    begin
                        flag_mismatch("right_out", right_out, want.right);
                    end
                end
                words_out++;
            end
            if (in_valid && in_ready)
            begin
                stereo_due.push_back(mix_sample(sample_in));
            end
        end
    end

    // Main sequence.
    initial
    begin
        logic signed [SAMPLE_W-1:0] basic_words [10];
        logic signed [SAMPLE_W-1:0] dry_words [6];
        logic signed [SAMPLE_W-1:0] edge_words [10];
        basic_words = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF,
                        16'sh5555, 16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh4000};
        dry_words = '{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001, 16'sh0000, 16'sh7FFE};
        edge_words = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                       16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001};

        dry_left_sh = RST_DRY_GAIN;
        dry_right_sh = RST_DRY_GAIN;
        tap_count_sh = RST_TAP_COUNT;
        tap_sel_sh = RST_TAP_SEL;
        for (int t = 0; t < TAPS; t++)
        begin
            tap_delay_sh[t] = RST_TAP_DELAY;
            tap_left_sh[t] = RST_TAP_GAIN;
            tap_right_sh[t] = RST_TAP_GAIN;
            tap_fb_sh[t] = RST_FB_GAIN;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Register defaults, extreme and patterned samples.
        foreach (basic_words[i])
        begin
            pending_samples.push_back(basic_words[i]);
        end
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        // Dry path only at the gain extremes, with no taps active.
        reg_write(REG_DRY_LEFT_GAIN, pad_gain(16'h7FFF));
        reg_write(REG_DRY_RIGHT_GAIN, pad_gain(16'h8000));
        reg_write(REG_TAP_COUNT, {14'($urandom), 4'd0});
        reg_write_end();
        foreach (dry_words[i])
        begin
            pending_samples.push_back(dry_words[i]);
        end
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        // Tap count above the slot count, delays below and above the clamp range.
        reg_write(REG_DRY_LEFT_GAIN, pad_gain(16'h8000));
        reg_write(REG_DRY_RIGHT_GAIN, pad_gain(16'h7FFF));
        for (int t = 0; t < TAPS; t++)
        begin
            program_tap(t, (t == TAPS - 1) ? 18'h3FFFF :
                           (t == TAPS - 2) ? 18'(STORE_DEPTH - DELAY_GUARD + 1) : 18'(t),
                        16'h7FFF, 16'h8000, t[0] ? 16'h8000 : 16'h7FFF);
        end
        reg_write(REG_TAP_COUNT, {14'($urandom), 4'd15});
        reg_write_end();
        foreach (edge_words[i])
        begin
            pending_samples.push_back(edge_words[i]);
        end
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        // Random settings; one setting drives every tap hard into saturation.
        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(REG_DRY_LEFT_GAIN, pad_gain(pick_gain()));
            reg_write(REG_DRY_RIGHT_GAIN, pad_gain(pick_gain()));
            for (int t = 0; t < TAPS; t++)
            begin
                if (ph == 4)
                begin
                    program_tap(t, 18'(MIN_TAP_DELAY + 8 * t),
                                t[0] ? 16'h8000 : 16'h7FFF,
                                t[1] ? 16'h8000 : 16'h7FFF, 16'h7FFF);
                end
                else
                begin
                    program_tap(t, pick_delay(), pick_gain(), pick_gain(), pick_gain());
                end
            end
            reg_write(REG_TAP_SELECT, 18'($urandom));
            if (ph == 4)
            begin
                reg_write(REG_TAP_COUNT, {14'($urandom), 4'd8});
            end
            else
            begin
                reg_write(REG_TAP_COUNT, 18'($urandom));
            end
            reg_write_end();

            sender_idles = (ph % 3) != 1;
            receiver_idles = (ph % 4) != 2;

            // First half, then the sender pauses until everything is back.
            for (int i = 0; i < 45; i++)
            begin
                pending_samples.push_back(pick_sample());
            end
            if (ph == 2 || ph == 5)
            begin
                long_hold_asked++;
            end
            wait_drained();
            for (int i = 0; i < 45; i++)
            begin
                pending_samples.push_back(pick_sample());
            end
            wait_drained();
            repeat (SETTLE) @(posedge clk);
        end

        if (error_count == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mfd_pkg.sv
sv/mfd_ram.sv
sv/mfd_mac.sv
sv/mfd_ctrl.sv
sv/multitap_feedback_delay.sv
dv/tb.sv
